// ===== hw/rtl/aps_pkg.sv =====
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and constants of the aging priority scheduler.
// ----------------------------------------------------------------------------
package aps_pkg;

    // number of process slots held in the slot memory
    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    // fixed field widths
    localparam int SLOT_W = 4;
    localparam int VAL_W  = 16;
    localparam int TIME_W = 32;

    localparam logic [VAL_W-1:0] PRIO_MAX = '1;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // one slot record as kept in memory
    typedef struct packed {
        logic [VAL_W-1:0] arrival;
        logic [VAL_W-1:0] remaining;
        logic [VAL_W-1:0] orig_burst;
        logic [VAL_W-1:0] prio;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_AGE  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

// ===== hw/rtl/aps_ram.sv =====
// ----------------------------------------------------------------------------
// aps_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module aps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/aging_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// aging_priority_scheduler
// Preemptive priority scheduler with aging over a memory of slot records.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken at a clock edge with start high and busy low.
//   opcode load writes one slot record (arrival, burst, priority) straight
//   into the slot memory; its all-zero result strobes on the next cycle and
//   busy never rises, so a new command may follow at once.
//   opcode tick runs a sequencer over the slot memory: a scan pass reads
//   every slot to pick the ready slot of highest priority (lowest slot on a
//   tie), then an aging pass reads each slot again and writes it back with
//   its priority raised if it has arrived (saturating) or, for the picked
//   slot, its burst lowered. Both passes walk the slot memory through its
//   single read port, one slot per cycle.
//   Each result is marked by o_strobe, high for a single cycle; the
//   receiver cannot stall and must take it then.
//   Reset clears the loaded flags, the time counter and the sequencer; the
//   slot memory is not cleared, since only loaded slots are ever used.
// ----------------------------------------------------------------------------
module aging_priority_scheduler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_opcode,
    input  logic [aps_pkg::SLOT_W-1:0] i_slot,
    input  logic [aps_pkg::VAL_W-1:0]  i_arrival_time,
    input  logic [aps_pkg::VAL_W-1:0]  i_burst_length,
    input  logic [aps_pkg::VAL_W-1:0]  i_start_priority,
    output logic                       o_strobe,
    output logic                       o_ran,
    output logic [aps_pkg::SLOT_W-1:0] o_run_slot,
    output logic                       o_finished,
    output logic [aps_pkg::TIME_W-1:0] o_completion_time,
    output logic [aps_pkg::TIME_W-1:0] o_turnaround,
    output logic [aps_pkg::TIME_W-1:0] o_waiting
);

    import aps_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_pv;
    logic [IDX_W-1:0]    r_pidx;
    logic [NUM_SLOTS-1:0] r_loaded;
    logic [TIME_W-1:0]   r_time;

    logic                r_found;
    logic [IDX_W-1:0]    r_pick;
    logic [VAL_W-1:0]    r_best;
    logic                r_pk_fin;
    logic [VAL_W-1:0]    r_pk_arr;
    logic [VAL_W:0]      r_pk_sub;

    logic                r_strobe, r_ran, r_fin;
    logic [SLOT_W-1:0]   r_run_slot;
    logic [TIME_W-1:0]   r_cmp, r_tat, r_wait;

    logic                accept, load_ok, last_data, issue;
    logic                arrived, ready, is_pick;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    t_entry              mem_wdata, rd, aged;
    logic [TIME_W-1:0]   time_nx;

    assign accept  = start && !busy;
    assign load_ok = (32'(i_slot) < NUM_SLOTS);
    assign busy    = (r_state != S_IDLE);
    assign issue   = (r_cnt < CNT_W'(NUM_SLOTS));
    assign last_data = r_pv && !issue;
    assign time_nx = r_time + 1'b1;

    // slot status of the word coming out of memory
    assign arrived = r_loaded[r_pidx] && ({{(TIME_W-VAL_W){1'b0}}, rd.arrival} <= r_time);
    assign ready   = arrived && (rd.remaining != '0);
    assign is_pick = r_found && (r_pidx == r_pick);

    // aged record written back during the second pass
    always_comb begin
        aged = rd;
        if (is_pick) begin
            aged.remaining = rd.remaining - 1'b1;
        end else if (arrived && rd.prio != PRIO_MAX) begin
            aged.prio = rd.prio + 1'b1;
        end
    end

    // memory write port: load command or write-back
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pidx;
        mem_wdata = aged;
        if (accept && i_opcode == OP_LOAD && load_ok) begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(i_slot);
            mem_wdata = '{arrival: i_arrival_time, remaining: i_burst_length,
                          orig_burst: i_burst_length, prio: i_start_priority};
        end else if (r_state == S_AGE && r_pv) begin
            mem_we = 1'b1;
        end
    end

    aps_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_SLOTS)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (rd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && i_opcode == OP_TICK) n_state = S_SCAN;
            S_SCAN: if (last_data) n_state = S_AGE;
            S_AGE:  if (last_data) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer, read tracking and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_loaded <= '0;
            r_time   <= '0;
            r_strobe <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            if (accept) begin
                r_cnt   <= '0;
                r_pv    <= 1'b0;
                r_found <= 1'b0;
                if (i_opcode == OP_LOAD) begin
                    r_strobe <= 1'b1;
                    if (load_ok) begin
                        r_loaded[IDX_W'(i_slot)] <= 1'b1;
                    end
                end
            end else if (r_state == S_SCAN || r_state == S_AGE) begin
                if (last_data) begin
                    r_cnt <= '0;
                    r_pv  <= 1'b0;
                end else begin
                    r_pv <= issue;
                    if (issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                if (r_state == S_SCAN && r_pv && ready && (!r_found || rd.prio > r_best)) begin
                    r_found <= 1'b1;
                end
            end else if (r_state == S_DONE) begin
                r_time   <= time_nx;
                r_strobe <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pidx <= r_cnt[IDX_W-1:0];
        // scan: keep best candidate
        if (r_state == S_SCAN && r_pv && ready && (!r_found || rd.prio > r_best)) begin
            r_pick <= r_pidx;
            r_best <= rd.prio;
        end
        // aging pass: capture picked slot's figures
        if (r_state == S_AGE && r_pv && is_pick) begin
            r_pk_fin <= (rd.remaining == VAL_W'(1));
            r_pk_arr <= rd.arrival;
            r_pk_sub <= {1'b0, rd.arrival} + {1'b0, rd.orig_burst};
        end
        // result word
        if (accept) begin
            r_ran      <= 1'b0;
            r_run_slot <= '0;
            r_fin      <= 1'b0;
            r_cmp      <= '0;
            r_tat      <= '0;
            r_wait     <= '0;
        end else if (r_state == S_DONE) begin
            r_ran      <= r_found;
            r_run_slot <= r_found ? SLOT_W'(r_pick) : '0;
            r_fin      <= r_found && r_pk_fin;
            if (r_found && r_pk_fin) begin
                r_cmp  <= time_nx;
                r_tat  <= time_nx - {{(TIME_W-VAL_W){1'b0}}, r_pk_arr};
                r_wait <= time_nx - {{(TIME_W-VAL_W-1){1'b0}}, r_pk_sub};
            end
        end
    end

    assign o_strobe          = r_strobe;
    assign o_ran             = r_ran;
    assign o_run_slot        = r_run_slot;
    assign o_finished        = r_fin;
    assign o_completion_time = r_cmp;
    assign o_turnaround      = r_tat;
    assign o_waiting         = r_wait;

endmodule

// ===== tb/aps_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aps_checker
// Watches the command and result channels of the aging priority scheduler,
// keeps its own copy of the slot table and the time counter, works out the
// result word of every accepted command and compares each strobed result
// field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module aps_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       i_opcode,
    input  logic [aps_pkg::SLOT_W-1:0] i_slot,
    input  logic [aps_pkg::VAL_W-1:0]  i_arrival_time,
    input  logic [aps_pkg::VAL_W-1:0]  i_burst_length,
    input  logic [aps_pkg::VAL_W-1:0]  i_start_priority,
    input  logic                       o_strobe,
    input  logic                       o_ran,
    input  logic [aps_pkg::SLOT_W-1:0] o_run_slot,
    input  logic                       o_finished,
    input  logic [aps_pkg::TIME_W-1:0] o_completion_time,
    input  logic [aps_pkg::TIME_W-1:0] o_turnaround,
    input  logic [aps_pkg::TIME_W-1:0] o_waiting,
    output int                         o_errors,
    output int                         o_pending
);
    import aps_pkg::*;

    typedef struct packed {
        logic              ran;
        logic [SLOT_W-1:0] run_slot;
        logic              finished;
        logic [TIME_W-1:0] completion;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
    } t_outcome;

    // shadow slot table and time counter
    logic [VAL_W-1:0]     arrival_tbl [NUM_SLOTS];
    logic [VAL_W-1:0]     remain_tbl  [NUM_SLOTS];
    logic [VAL_W-1:0]     burst_tbl   [NUM_SLOTS];
    logic [VAL_W-1:0]     prio_tbl    [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] loaded_vec;
    logic [TIME_W-1:0]    now_time;

    // result words owed by the block, oldest first
    t_outcome owed_outcomes [$];
    int       mismatch_cnt;

    assign o_errors = mismatch_cnt;

    function automatic logic slot_arrived(input int s);
        return loaded_vec[s] && (TIME_W'(arrival_tbl[s]) <= now_time);
    endfunction

    // one command applied to the shadow table; returns the result word
    function automatic t_outcome advance_schedule(
        input logic              op,
        input logic [SLOT_W-1:0] slot,
        input logic [VAL_W-1:0]  arrival,
        input logic [VAL_W-1:0]  burst,
        input logic [VAL_W-1:0]  prio
    );
        t_outcome          res;
        logic              found;
        int                pick;
        int                s;
        logic [VAL_W-1:0]  best;
        logic [TIME_W-1:0] tat;
        res   = '0;
        found = 1'b0;
        pick  = 0;
        best  = '0;
        if (op == OP_LOAD) begin
            // a load overwrites the whole record, even one still running
            if (int'(slot) < NUM_SLOTS) begin
                arrival_tbl[slot] = arrival;
                remain_tbl[slot]  = burst;
                burst_tbl[slot]   = burst;
                prio_tbl[slot]    = prio;
                loaded_vec[slot]  = 1'b1;
            end
            return res;
        end
        // pick the ready slot of highest priority, lowest index on a tie
        for (s = 0; s < NUM_SLOTS; s++) begin
            if (slot_arrived(s) && remain_tbl[s] != '0 && (!found || prio_tbl[s] > best)) begin
                found = 1'b1;
                pick  = s;
                best  = prio_tbl[s];
            end
        end
        // every other arrived slot ages, finished ones too, saturating
        for (s = 0; s < NUM_SLOTS; s++) begin
            if ((!found || s != pick) && slot_arrived(s) && prio_tbl[s] != PRIO_MAX)
                prio_tbl[s] = prio_tbl[s] + 1'b1;
        end
        now_time = now_time + 1'b1;
        if (found) begin
            remain_tbl[pick] = remain_tbl[pick] - 1'b1;
            res.ran      = 1'b1;
            res.run_slot = SLOT_W'(pick);
            if (remain_tbl[pick] == '0) begin
                tat            = now_time - TIME_W'(arrival_tbl[pick]);
                res.finished   = 1'b1;
                res.completion = now_time;
                res.turnaround = tat;
                res.waiting    = tat - TIME_W'(burst_tbl[pick]);
            end
        end
        return res;
    endfunction

    function automatic void check_field(
        input string             name,
        input logic [TIME_W-1:0] exp_v,
        input logic [TIME_W-1:0] act_v
    );
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatch_cnt++;
        end
    endfunction

    // sample both channels at the rising edge
    always @(posedge i_clk) begin : watch_blk
        t_outcome exp_o;
        int       s;
        if (!i_rst_n) begin
            for (s = 0; s < NUM_SLOTS; s++) begin
                arrival_tbl[s] = '0;
                remain_tbl[s]  = '0;
                burst_tbl[s]   = '0;
                prio_tbl[s]    = '0;
            end
            loaded_vec = '0;
            now_time   = '0;
            owed_outcomes.delete();
        end else begin
            if (o_strobe) begin
                if (owed_outcomes.size() == 0) begin
                    $display("%0t: result word with none expected (ran %0b slot %0d)",
                             $time, o_ran, o_run_slot);
                    mismatch_cnt++;
                end else begin
                    exp_o = owed_outcomes.pop_front();
                    check_field("ran", TIME_W'(exp_o.ran), TIME_W'(o_ran));
                    check_field("run_slot", TIME_W'(exp_o.run_slot), TIME_W'(o_run_slot));
                    check_field("finished", TIME_W'(exp_o.finished), TIME_W'(o_finished));
                    check_field("completion_time", exp_o.completion, o_completion_time);
                    check_field("turnaround", exp_o.turnaround, o_turnaround);
                    check_field("waiting", exp_o.waiting, o_waiting);
                end
            end
            if (start && !busy)
                owed_outcomes.push_back(advance_schedule(i_opcode, i_slot, i_arrival_time,
                                                         i_burst_length, i_start_priority));
        end
        o_pending <= owed_outcomes.size();
    end

endmodule

// ===== tb/tb_aging_priority_scheduler.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aging_priority_scheduler
// Drives load and tick command words into the scheduler: a directed opening
// (idle ticks, ties, saturation, reload mid-run, late arrival, zero burst),
// then random traffic in phases with and without sender gaps. The checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_aging_priority_scheduler;
    import aps_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1350;
    localparam int NUM_PHASES   = 3;
    localparam int TAIL_CYCLES  = 2 * NUM_SLOTS + 8;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_opcode;
    logic [SLOT_W-1:0] i_slot;
    logic [VAL_W-1:0]  i_arrival_time;
    logic [VAL_W-1:0]  i_burst_length;
    logic [VAL_W-1:0]  i_start_priority;
    logic              o_strobe;
    logic              o_ran;
    logic [SLOT_W-1:0] o_run_slot;
    logic              o_finished;
    logic [TIME_W-1:0] o_completion_time;
    logic [TIME_W-1:0] o_turnaround;
    logic [TIME_W-1:0] o_waiting;

    int err_cnt;
    int pending_cnt;
    int cycle_cnt  = 0;
    int ticks_sent = 0;
    int idle_pct   = 0;

    // percent of sender idle cycles per random phase
    int phase_idle [NUM_PHASES] = '{0, 46, 38};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    aging_priority_scheduler u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_slot            (i_slot),
        .i_arrival_time    (i_arrival_time),
        .i_burst_length    (i_burst_length),
        .i_start_priority  (i_start_priority),
        .o_strobe          (o_strobe),
        .o_ran             (o_ran),
        .o_run_slot        (o_run_slot),
        .o_finished        (o_finished),
        .o_completion_time (o_completion_time),
        .o_turnaround      (o_turnaround),
        .o_waiting         (o_waiting)
    );

    aps_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_slot            (i_slot),
        .i_arrival_time    (i_arrival_time),
        .i_burst_length    (i_burst_length),
        .i_start_priority  (i_start_priority),
        .o_strobe          (o_strobe),
        .o_ran             (o_ran),
        .o_run_slot        (o_run_slot),
        .o_finished        (o_finished),
        .o_completion_time (o_completion_time),
        .o_turnaround      (o_turnaround),
        .o_waiting         (o_waiting),
        .o_errors          (err_cnt),
        .o_pending         (pending_cnt)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_aging_priority_scheduler: done, errors");
            $finish;
        end
    end

    // present one command word and hold it until the block takes it
    task automatic send_word(
        input logic              op,
        input logic [SLOT_W-1:0] slot,
        input logic [VAL_W-1:0]  arrival,
        input logic [VAL_W-1:0]  burst,
        input logic [VAL_W-1:0]  prio
    );
        int gap;
        gap = 0;
        if (idle_pct > 0) begin
            while (gap < 12 && $urandom_range(99) < idle_pct)
                gap++;
            // now and then a long pause before the word is presented
            if ($urandom_range(9) == 0)
                gap += $urandom_range(40, 1);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_opcode         <= op;
        i_slot           <= slot;
        i_arrival_time   <= arrival;
        i_burst_length   <= burst;
        i_start_priority <= prio;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (op == OP_TICK)
            ticks_sent++;
    endtask

    initial begin
        logic [SLOT_W-1:0] slot_v;
        logic [VAL_W-1:0]  arr_v;
        logic [VAL_W-1:0]  burst_v;
        logic [VAL_W-1:0]  prio_v;
        int                r;

        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_opcode         <= OP_LOAD;
        i_slot           <= '0;
        i_arrival_time   <= '0;
        i_burst_length   <= '0;
        i_start_priority <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle tick on an empty table
        send_word(OP_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000);
        // equal priorities: lowest slot wins, then aging flips the order
        send_word(OP_LOAD, 4'd0, 16'h0000, 16'd2, 16'd5);
        send_word(OP_LOAD, 4'd15, 16'h0000, 16'd1, 16'd5);
        send_word(OP_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000);
        send_word(OP_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000);
        send_word(OP_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000);
        // zero burst at top priority: never runs, stays saturated
        send_word(OP_LOAD, 4'd3, 16'h0000, 16'h0000, 16'hFFFF);
        // arrival far beyond the run: never ready
        send_word(OP_LOAD, 4'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(OP_LOAD, 4'd5, 16'h0000, 16'd3, 16'hFFFE);
        send_word(OP_TICK, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // reload while still running
        send_word(OP_LOAD, 4'd5, 16'h0000, 16'd1, 16'h0000);
        send_word(OP_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000);
        // late arrival: idle until its tick comes
        send_word(OP_LOAD, 4'd9, VAL_W'(ticks_sent + 2), 16'd1, 16'd10);
        send_word(OP_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000);
        send_word(OP_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000);
        send_word(OP_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000);
        // longest burst, then retired by a reload with no work
        send_word(OP_LOAD, 4'd10, 16'h0000, 16'hFFFF, 16'h0000);
        send_word(OP_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000);
        send_word(OP_LOAD, 4'd10, 16'h0000, 16'h0000, 16'h0000);
        send_word(OP_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000);

        // random traffic, one sender idle rate per phase
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            idle_pct = phase_idle[ph];
            repeat (RANDOM_WORDS / NUM_PHASES) begin
                if ($urandom_range(99) < 35) begin
                    slot_v = SLOT_W'($urandom_range(NUM_SLOTS - 1));
                    r = $urandom_range(99);
                    if (r < 75)
                        arr_v = VAL_W'(ticks_sent + $urandom_range(12));
                    else if (r < 90)
                        arr_v = VAL_W'($urandom_range(ticks_sent));
                    else
                        arr_v = VAL_W'($urandom);
                    r = $urandom_range(99);
                    if (r < 6)
                        burst_v = '0;
                    else if (r < 92)
                        burst_v = VAL_W'($urandom_range(10, 1));
                    else
                        burst_v = VAL_W'($urandom);
                    r = $urandom_range(99);
                    if (r < 70)
                        prio_v = VAL_W'($urandom_range(60));
                    else if (r < 85)
                        prio_v = VAL_W'($urandom);
                    else
                        prio_v = VAL_W'($urandom_range(16'hFFFF, 16'hFFF0));
                    send_word(OP_LOAD, slot_v, arr_v, burst_v, prio_v);
                end else begin
                    // unused fields of a tick carry noise
                    send_word(OP_TICK, SLOT_W'($urandom), VAL_W'($urandom),
                              VAL_W'($urandom), VAL_W'($urandom));
                end
            end
        end
        start <= 1'b0;

        // drain, then let the block settle
        @(posedge i_clk);
        while (pending_cnt != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (err_cnt == 0)
            $display("tb_aging_priority_scheduler: done, clean");
        else
            $display("tb_aging_priority_scheduler: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/aps_pkg.sv
hw/rtl/aps_ram.sv
hw/rtl/aging_priority_scheduler.sv
tb/aps_checker.sv
tb/tb_aging_priority_scheduler.sv
